### hdl/crc32_word_stream_assert.svh
// ----------------------------------------------------------------------------
// crc32_word_stream assertion macros
// Concurrent assertion shorthands shared by the CRC word stream design.
// ----------------------------------------------------------------------------
`ifndef CRC32_WORD_STREAM_ASSERT_SVH
`define CRC32_WORD_STREAM_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CWS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("crc32_word_stream: assertion failed");

// next-cycle implication, disabled during reset
`define CWS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("crc32_word_stream: assertion failed");

`endif

### hdl/crc32ws_pkg.sv
// ----------------------------------------------------------------------------
// crc32ws_pkg
// Shared types, constants and a helper function of the CRC word stream.
// ----------------------------------------------------------------------------
package crc32ws_pkg;

    localparam int WORD_W      = 32;
    localparam int TAB_W       = $clog2(WORD_W);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W   = 1;

    localparam logic [WORD_W-1:0] POLY_RESET = 32'h04C1_1DB7;
    localparam logic [WORD_W-1:0] INIT_RESET = 32'hFFFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POLYNOMIAL    = 1'b0,
        REG_INITIAL_VALUE = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [WORD_W-1:0] data_word;
        logic              last_word;
    } word_item_t;

    // one bit of MSB-first division with a zero data bit
    function automatic logic [WORD_W-1:0] crc_step(
        input logic [WORD_W-1:0] r,
        input logic [WORD_W-1:0] poly
    );
        return {r[WORD_W-2:0], 1'b0} ^ (r[WORD_W-1] ? poly : '0);
    endfunction

endpackage

### hdl/crc32ws_if.sv
// ----------------------------------------------------------------------------
// crc32ws_if
// Valid/ready channel interfaces for message words and CRC results.
// ----------------------------------------------------------------------------
interface crc32ws_word_if;
    import crc32ws_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] data_word;
    logic              last_word;

    modport source (output valid, output data_word, output last_word, input ready);
    modport sink   (input valid, input data_word, input last_word, output ready);
endinterface

interface crc32ws_crc_if;
    import crc32ws_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] crc_value;

    modport source (output valid, output crc_value, input ready);
    modport sink   (input valid, input crc_value, output ready);
endinterface

### hdl/crc32ws_front.sv
// ----------------------------------------------------------------------------
// crc32ws_front
// Input stage: accepts word transactions, tags the last word, feeds the queue.
// ----------------------------------------------------------------------------
module crc32ws_front (
    input  logic                    clk,
    input  logic                    rst_n,
    crc32ws_word_if.sink            word_ch,
    input  logic                    building,
    output logic                    push_valid,
    input  logic                    push_ready,
    output crc32ws_pkg::word_item_t push_item
);
    import crc32ws_pkg::*;

    logic       hold_valid_reg;
    logic       hold_valid_next;
    word_item_t hold_item_reg;
    logic       accept;

    always_comb
    begin
        word_ch.ready   = !building && (!hold_valid_reg || push_ready);
        accept          = word_ch.valid && word_ch.ready;
        hold_valid_next = accept || (hold_valid_reg && !push_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_item_reg.data_word <= word_ch.data_word;
            hold_item_reg.last_word <= word_ch.last_word;
        end
    end

    assign push_valid = hold_valid_reg;
    assign push_item  = hold_item_reg;

endmodule

### hdl/crc32ws_fifo.sv
// ----------------------------------------------------------------------------
// crc32ws_fifo
// Short queue between the input stage and the CRC engine.
// ----------------------------------------------------------------------------
module crc32ws_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push_valid,
    output logic                    push_ready,
    input  crc32ws_pkg::word_item_t push_item,
    output logic                    pop_valid,
    input  logic                    pop_ready,
    output crc32ws_pkg::word_item_t pop_item
);
    import crc32ws_pkg::*;

    word_item_t        mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              pop;

    always_comb
    begin
        push_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
        pop_valid   = (count_reg != '0);
        pop_item    = mem_reg[rd_ptr_reg];
        push        = push_valid && push_ready;
        pop         = pop_valid && pop_ready;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### hdl/crc32ws_back.sv
// ----------------------------------------------------------------------------
// crc32ws_back
// CRC engine: folds one word per cycle through a polynomial column table unless
// rebuilding or stalled on crc_ch; holds the configuration and result registers.
// ----------------------------------------------------------------------------
module crc32ws_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [crc32ws_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [crc32ws_pkg::WORD_W-1:0] wr_data,
    input  logic                           pop_valid,
    output logic                           pop_ready,
    input  crc32ws_pkg::word_item_t        pop_item,
    output logic                           building,
    crc32ws_crc_if.source                  crc_ch
);
    import crc32ws_pkg::*;

    logic [WORD_W-1:0] poly_reg;
    logic [WORD_W-1:0] col_reg;
    logic [TAB_W-1:0]  build_cnt_reg;
    logic              building_reg;
    logic [WORD_W-1:0] table_reg [WORD_W];
    logic [WORD_W-1:0] init_reg;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] rem_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [WORD_W-1:0] crc_reg;
    logic [WORD_W-1:0] folded;
    logic [WORD_W-1:0] mixed;
    logic              pop;
    logic              poly_wr;
    logic              init_wr;

    always_comb
    begin
        poly_wr = 1'b0;
        init_wr = 1'b0;
        if (wr_en)
        begin
            case (wr_index)
                REG_POLYNOMIAL:    poly_wr = 1'b1;
                REG_INITIAL_VALUE: init_wr = 1'b1;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        mixed  = rem_reg ^ pop_item.data_word;
        folded = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (mixed[i])
            begin
                folded = folded ^ table_reg[i];
            end
        end
    end

    always_comb
    begin
        pop_ready = !building_reg
                    && (!pop_item.last_word || !out_valid_reg || crc_ch.ready);
        pop       = pop_valid && pop_ready;
        rem_next  = rem_reg;
        if (pop)
        begin
            rem_next = pop_item.last_word ? init_reg : folded;
        end
        out_valid_next = out_valid_reg && !crc_ch.ready;
        if (pop && pop_item.last_word)
        begin
            out_valid_next = 1'b1;
        end
    end

    // rebuild column table: column i is i division steps applied to the polynomial
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg      <= POLY_RESET;
            col_reg       <= POLY_RESET;
            build_cnt_reg <= '0;
            building_reg  <= 1'b1;
            init_reg      <= INIT_RESET;
            rem_reg       <= INIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (poly_wr)
            begin
                poly_reg      <= wr_data;
                col_reg       <= wr_data;
                build_cnt_reg <= '0;
                building_reg  <= 1'b1;
            end
            else if (building_reg)
            begin
                col_reg       <= crc_step(col_reg, poly_reg);
                build_cnt_reg <= build_cnt_reg + 1'b1;
                if (build_cnt_reg == TAB_W'(WORD_W - 1))
                begin
                    building_reg <= 1'b0;
                end
            end
            if (init_wr)
            begin
                init_reg <= wr_data;
            end
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (building_reg && !poly_wr)
        begin
            table_reg[build_cnt_reg] <= col_reg;
        end
        if (pop && pop_item.last_word)
        begin
            crc_reg <= folded;
        end
    end

    assign building         = building_reg;
    assign crc_ch.valid     = out_valid_reg;
    assign crc_ch.crc_value = crc_reg;

endmodule

### hdl/crc32_word_stream.sv
// ----------------------------------------------------------------------------
// crc32_word_stream
// Running CRC-32 (MSB first, no reflection, no final XOR) over 32-bit words.
//
//   channel   dir   handshake      payload
//   word_ch   in    valid/ready    data_word[31:0], last_word
//   crc_ch    out   valid/ready    crc_value[31:0]
//   wr_*      in    wr_en strobe   wr_index (0 polynomial, 1 initial value), wr_data
//
// One word per cycle unless a table rebuild or crc_ch stall holds it; the remainder
// update is a single XOR pass over a 32-column table derived from the polynomial.
// An accepted word passes the input holding register and the queue to the engine,
// whose result register holds the CRC. After reset and after each polynomial write
// the table is rebuilt, during which no word is accepted. The result register and
// a 2-entry queue let input run while crc_ch stalls.
// ----------------------------------------------------------------------------
`include "crc32_word_stream_assert.svh"

module crc32_word_stream (
    input  logic                              clk,
    input  logic                              rst_n,
    crc32ws_word_if.sink                      word_ch,
    crc32ws_crc_if.source                     crc_ch,
    input  logic                              wr_en,
    input  logic [crc32ws_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [crc32ws_pkg::WORD_W-1:0]    wr_data
);
    import crc32ws_pkg::*;

    logic       building;
    logic       front_valid;
    logic       front_ready;
    word_item_t front_item;
    logic       q_valid;
    logic       q_ready;
    word_item_t q_item;
    logic       last_pop;

    crc32ws_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_ch    (word_ch),
        .building   (building),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item)
    );

    crc32ws_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    crc32ws_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .pop_valid (q_valid),
        .pop_ready (q_ready),
        .pop_item  (q_item),
        .building  (building),
        .crc_ch    (crc_ch)
    );

    assign last_pop = q_valid && q_ready && q_item.last_word;

    `CWS_ASSERT_IMP(a_no_accept_building, clk, rst_n, building, !word_ch.ready)
    `CWS_ASSERT_IMP(a_no_pop_building, clk, rst_n, building, !(q_valid && q_ready))
    `CWS_ASSERT_IMP(a_last_has_slot, clk, rst_n, last_pop, !crc_ch.valid || crc_ch.ready)
    `CWS_ASSERT_NEXT(a_last_gives_result, clk, rst_n, last_pop, crc_ch.valid)

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the CRC-32 word stream. A directed table walks the
// extremes and register changes inside a message. Random messages follow
// under three handshake idling patterns. Every CRC is compared in order with a
// bit-serial model of the division kept by the bench, or with a row's typed CRC.
// ----------------------------------------------------------------------------
module tb;
    import crc32ws_pkg::*;

    localparam int  HALF_PERIOD   = 10;
    localparam int  DRAIN_CYCLES  = 8;
    localparam int  RANDOM_WORDS  = 200;
    localparam int  REPORT_LIMIT  = 10;
    localparam int  NUM_ROWS      = 24;

    typedef enum logic [0:0] {
        ROW_WORD,
        ROW_WRITE
    } row_kind_t;

    typedef struct {
        row_kind_t         kind;
        cfg_reg_t          index;
        logic [WORD_W-1:0] value;
        logic              last_word;
        logic              typed;
        logic [WORD_W-1:0] crc;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [WORD_W-1:0] wr_data;

    crc32ws_word_if word_ch ();
    crc32ws_crc_if  crc_ch ();

    logic [WORD_W-1:0] poly_setting  = POLY_RESET;
    logic [WORD_W-1:0] init_setting  = INIT_RESET;
    logic [WORD_W-1:0] crc_remainder = INIT_RESET;
    logic [WORD_W-1:0] crc_expected [$];
    int mismatch_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    stim_row_t directed_rows [NUM_ROWS] = '{
        '{ROW_WORD,  REG_POLYNOMIAL,    32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000},
        '{ROW_WORD,  REG_POLYNOMIAL,    32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
        '{ROW_WORD,  REG_POLYNOMIAL,    32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_WORD,  REG_POLYNOMIAL,    32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
        '{ROW_WRITE, REG_INITIAL_VALUE, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_WORD,  REG_POLYNOMIAL,    32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
        '{ROW_WORD,  REG_POLYNOMIAL,    32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
        '{ROW_WORD,  REG_POLYNOMIAL,    32'h8000_0000, 1'b1, 1'b0, 32'h0000_0000},
        '{ROW_WRITE, REG_POLYNOMIAL,    32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_WORD,  REG_POLYNOMIAL,    32'h1234_5678, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_WORD,  REG_POLYNOMIAL,    32'h9ABC_DEF0, 1'b1, 1'b1, 32'h0000_0000},
        '{ROW_WRITE, REG_POLYNOMIAL,    32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_WORD,  REG_POLYNOMIAL,    32'hA5A5_A5A5, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_WORD,  REG_POLYNOMIAL,    32'h5A5A_5A5A, 1'b1, 1'b0, 32'h0000_0000},
        '{ROW_WRITE, REG_INITIAL_VALUE, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_WORD,  REG_POLYNOMIAL,    32'hDEAD_BEEF, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_WRITE, REG_POLYNOMIAL,    32'h04C1_1DB7, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_WORD,  REG_POLYNOMIAL,    32'hCAFE_F00D, 1'b1, 1'b0, 32'h0000_0000},
        '{ROW_WORD,  REG_POLYNOMIAL,    32'h1111_1111, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_WRITE, REG_INITIAL_VALUE, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_WORD,  REG_POLYNOMIAL,    32'h2222_2222, 1'b1, 1'b0, 32'h0000_0000},
        '{ROW_WORD,  REG_POLYNOMIAL,    32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
        '{ROW_WRITE, REG_INITIAL_VALUE, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0000_0000},
        '{ROW_WORD,  REG_POLYNOMIAL,    32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000}
    };

    crc32_word_stream i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .word_ch  (word_ch),
        .crc_ch   (crc_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    initial
    begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [WORD_W-1:0] crc_fold(
        input logic [WORD_W-1:0] rem,
        input logic [WORD_W-1:0] word,
        input logic [WORD_W-1:0] poly
    );
        logic [WORD_W-1:0] r;
        logic              fb;
        r = rem;
        for (int b = WORD_W - 1; b >= 0; b--)
        begin
            fb = r[WORD_W-1] ^ word[b];
            r  = {r[WORD_W-2:0], 1'b0} ^ (fb ? poly : '0);
        end
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return 32'h1 << $urandom_range(WORD_W - 1);
            3: return ~(32'h1 << $urandom_range(WORD_W - 1));
            default: return $urandom;
        endcase
    endfunction

    always @(posedge clk)
    begin
        crc_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && crc_ch.valid && crc_ch.ready)
        begin
            if (crc_expected.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected crc transaction: got %08h", crc_ch.crc_value);
            end
            else
            begin
                if (crc_ch.crc_value !== crc_expected[0])
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("crc mismatch: expected %08h, got %08h",
                                 crc_expected[0], crc_ch.crc_value);
                end
                void'(crc_expected.pop_front());
            end
        end
    end

    task automatic send_word(
        input logic [WORD_W-1:0] data,
        input logic              last,
        input logic              typed,
        input logic [WORD_W-1:0] typed_crc
    );
        while ($urandom_range(99) < send_idle_pct)
        begin
            word_ch.valid <= 1'b0;
            @(posedge clk);
        end
        word_ch.valid     <= 1'b1;
        word_ch.data_word <= data;
        word_ch.last_word <= last;
        @(posedge clk);
        while (!word_ch.ready)
            @(posedge clk);
        crc_remainder = crc_fold(crc_remainder, data, poly_setting);
        if (last)
        begin
            crc_expected = {crc_expected, (typed ? typed_crc : crc_remainder)};
            crc_remainder = init_setting;
        end
    endtask

    // drop valid, wait for all results, then let in-flight words retire
    task automatic settle();
        word_ch.valid <= 1'b0;
        while (crc_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t index, input logic [WORD_W-1:0] value);
        settle();
        wr_en    <= 1'b1;
        wr_index <= index;
        wr_data  <= value;
        @(posedge clk);
        wr_en <= 1'b0;
        if (index == REG_POLYNOMIAL)
            poly_setting = value;
        else
            init_setting = value;
    endtask

    initial
    begin
        int       words_sent;
        int       msg_len;
        cfg_reg_t rand_index;

        word_ch.valid     <= 1'b0;
        word_ch.data_word <= '0;
        word_ch.last_word <= 1'b0;
        wr_en             <= 1'b0;
        wr_index          <= REG_POLYNOMIAL;
        wr_data           <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            if (directed_rows[i].kind == ROW_WRITE)
                write_reg(directed_rows[i].index, directed_rows[i].value);
            else
                send_word(directed_rows[i].value, directed_rows[i].last_word,
                          directed_rows[i].typed, directed_rows[i].crc);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 33;
                    recv_idle_pct = 59;
                    write_reg(REG_POLYNOMIAL, POLY_RESET);
                    write_reg(REG_INITIAL_VALUE, INIT_RESET);
                end
                1:
                begin
                    send_idle_pct = 59;
                    recv_idle_pct = 33;
                    write_reg(REG_POLYNOMIAL, $urandom);
                    write_reg(REG_INITIAL_VALUE, '0);
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    write_reg(REG_POLYNOMIAL, '1);
                    write_reg(REG_INITIAL_VALUE, $urandom);
                end
            endcase

            words_sent = 0;
            while (words_sent < RANDOM_WORDS)
            begin
                msg_len = ($urandom_range(9) == 0) ? $urandom_range(5, 16)
                                                   : $urandom_range(1, 4);
                for (int w = 1; w <= msg_len; w++)
                begin
                    // change a register inside the message now and then
                    if (w > 1 && $urandom_range(49) == 0)
                    begin
                        rand_index = cfg_reg_t'($urandom_range(1));
                        write_reg(rand_index, rand_word());
                    end
                    send_word(rand_word(), w == msg_len, 1'b0, '0);
                    words_sent++;
                end
                if ($urandom_range(29) == 0)
                begin
                    rand_index = cfg_reg_t'($urandom_range(1));
                    write_reg(rand_index, rand_word());
                end
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
